[src/tops_pkg.sv]
// shared types and constants of the timed output pattern sequencer
package tops_pkg;

	// table geometry and output count limits
	localparam int MAX_STEPS   = 64;
	localparam int STEP_AW     = 6;
	localparam int MAX_OUTPUTS = 8;
	localparam int CH_W        = 3;

	// item kinds carried on the input tuser
	localparam logic [1:0] MODE_LOAD   = 2'd0;
	localparam logic [1:0] MODE_START  = 2'd1;
	localparam logic [1:0] MODE_TICK   = 2'd2;
	localparam logic [1:0] MODE_DIRECT = 2'd3;

	localparam logic [3:0]  OUT_COUNT_RST = 4'd4;
	localparam logic [15:0] SEL_ALL       = 16'hFFFF;
	localparam logic [7:0]  LEVEL_MAX     = 8'd255;

	// one table slot
	typedef struct packed {
		logic [15:0] sel;
		logic [15:0] pow;
		logic [15:0] dur;
	} step_entry_t;

	// request to the selector wrap unit
	typedef struct packed {
		logic        start;
		logic [15:0] dividend;
		logic [3:0]  divisor;
	} mod_req_t;

	// answer of the selector wrap unit
	typedef struct packed {
		logic            done;
		logic [CH_W-1:0] rem;
	} mod_rsp_t;

	// power request clamped to 0..255
	function automatic logic [7:0] clamp_level(input logic [15:0] pow);
		logic [7:0] lvl;
		if (pow[15]) begin
			lvl = 8'd0;
		end else if (pow[14:8] != 7'd0) begin
			lvl = LEVEL_MAX;
		end else begin
			lvl = pow[7:0];
		end
		return lvl;
	endfunction

endpackage

[src/timed_output_pattern_sequencer.sv]
// Timed output pattern sequencer top level: item control, step table and result register.
// A direct item to one output waits for the selector wrap unit to reduce the selector by
// out_count; a step advance first reads the next slot. An all-outputs write emits one result
// per cycle while the receiver does not stall.
// Reset (arst_n low) clears the sequencer state, out_count to 4 and the result valid flag;
// the step table is not cleared and holds no data until written.
module timed_output_pattern_sequencer
	import tops_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [3:0]  cfg_wdata,   // out_count
	input  logic        s_tvalid,
	output logic        s_tready,
	// step_index[5:0], out_select[21:6], power_request[37:22], step_duration[53:38], zero pad
	input  logic [55:0] s_tdata,
	input  logic [1:0]  s_tuser,     // mode[1:0]
	input  logic        s_tlast,     // is_last_step
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,     // channel[2:0], level[10:3], zero pad
	output logic [1:0]  m_tuser,     // write_valid[0], pattern_done[1]
	output logic        m_tlast      // last_of_run
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_TICK  = 3'd1;
	localparam logic [2:0] ST_FETCH = 3'd2;
	localparam logic [2:0] ST_APPLY = 3'd3;
	localparam logic [2:0] ST_WRAP  = 3'd4;
	localparam logic [2:0] ST_ONE   = 3'd5;
	localparam logic [2:0] ST_ALL   = 3'd6;
	localparam logic [2:0] ST_DONE  = 3'd7;

	logic [2:0]         state_q;
	logic [3:0]         out_count_q;
	logic [STEP_AW-1:0] final_q;
	logic [STEP_AW-1:0] cur_q;
	logic [16:0]        tick_q;
	logic               running_q;
	logic [15:0]        sel_q;
	logic [15:0]        pow_q;
	logic [CH_W-1:0]    ch_q;

	logic               m_valid_q;
	logic [CH_W-1:0]    m_ch_q;
	logic [7:0]         m_lvl_q;
	logic               m_wv_q;
	logic               m_done_q;
	logic               m_last_q;

	// input beat fields
	logic               s_fire;
	logic [1:0]         in_mode;
	logic [STEP_AW-1:0] in_slot;
	logic [15:0]        in_sel;
	logic [15:0]        in_pow;
	logic [15:0]        in_dur;

	assign s_tready = (state_q == ST_IDLE);
	assign s_fire   = s_tvalid && s_tready;
	assign in_mode  = s_tuser;
	assign in_slot  = s_tdata[5:0];
	assign in_sel   = s_tdata[21:6];
	assign in_pow   = s_tdata[37:22];
	assign in_dur   = s_tdata[53:38];

	// outputs in use, clamped to 1..MAX_OUTPUTS
	logic [3:0] n_out;
	always_comb begin
		if (out_count_q == 4'd0) begin
			n_out = 4'd1;
		end else if (out_count_q > 4'(MAX_OUTPUTS)) begin
			n_out = 4'(MAX_OUTPUTS);
		end else begin
			n_out = out_count_q;
		end
	end

	// step table
	logic               wr_en;
	step_entry_t        wr_data;
	logic               rd_en;
	logic [STEP_AW-1:0] rd_addr;
	step_entry_t        rd_data;

	assign wr_en   = s_fire && (in_mode == MODE_LOAD);
	assign wr_data = '{sel: in_sel, pow: in_pow, dur: in_dur};

	// tick decision against the current step
	logic tick_end;
	logic at_final;
	assign tick_end = (tick_q > {1'b0, rd_data.dur});
	assign at_final = (cur_q == final_q);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = cur_q;
		if (s_fire && (in_mode == MODE_START)) begin
			rd_en   = 1'b1;
			rd_addr = '0;
		end else if (s_fire && (in_mode == MODE_TICK) && running_q) begin
			rd_en = 1'b1;
		end else if ((state_q == ST_TICK) && tick_end && !at_final) begin
			rd_en   = 1'b1;
			rd_addr = cur_q + STEP_AW'(1);
		end
	end

	tops_step_mem u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (in_slot),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// selector wrap
	mod_req_t mod_req;
	mod_rsp_t mod_rsp;
	logic [15:0] sel_mag;

	assign sel_mag          = sel_q[15] ? (~sel_q + 16'd1) : sel_q;
	assign mod_req.start    = (state_q == ST_APPLY) && (sel_q != SEL_ALL);
	assign mod_req.dividend = sel_mag;
	assign mod_req.divisor  = n_out;

	tops_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mod_req),
		.rsp    (mod_rsp)
	);

	// result beat to emit this cycle
	logic            out_free;
	logic            emit;
	logic [CH_W-1:0] e_ch;
	logic [7:0]      e_lvl;
	logic            e_wv;
	logic            e_done;
	logic            e_last;
	logic            all_last;

	assign out_free = !m_valid_q || m_tready;
	assign all_last = ({1'b0, ch_q} == (n_out - 4'd1));

	always_comb begin
		emit   = 1'b0;
		e_ch   = ch_q;
		e_lvl  = clamp_level(pow_q);
		e_wv   = 1'b1;
		e_done = 1'b0;
		e_last = 1'b1;
		unique case (state_q)
			ST_ONE: begin
				emit = out_free;
			end
			ST_ALL: begin
				emit   = out_free;
				e_last = all_last;
			end
			ST_DONE: begin
				emit   = out_free;
				e_ch   = '0;
				e_lvl  = '0;
				e_wv   = 1'b0;
				e_done = 1'b1;
			end
			ST_IDLE, ST_TICK, ST_FETCH, ST_APPLY, ST_WRAP: begin
				emit = 1'b0;
			end
		endcase
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_count_q <= OUT_COUNT_RST;
		end else if (cfg_wen) begin
			out_count_q <= cfg_wdata;
		end
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			final_q   <= '0;
			cur_q     <= '0;
			tick_q    <= '0;
			running_q <= 1'b0;
			ch_q      <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						unique case (in_mode)
							MODE_LOAD: begin
								if (s_tlast) begin
									final_q <= in_slot;
								end
							end
							MODE_START: begin
								cur_q     <= '0;
								tick_q    <= '0;
								running_q <= 1'b1;
								state_q   <= ST_FETCH;
							end
							MODE_TICK: begin
								if (running_q) begin
									tick_q  <= tick_q + 17'd1;
									state_q <= ST_TICK;
								end
							end
							MODE_DIRECT: begin
								state_q <= ST_APPLY;
							end
						endcase
					end
				end
				ST_TICK: begin
					if (!tick_end) begin
						state_q <= ST_IDLE;
					end else begin
						tick_q <= '0;
						if (at_final) begin
							cur_q     <= '0;
							running_q <= 1'b0;
							state_q   <= ST_DONE;
						end else begin
							cur_q   <= cur_q + STEP_AW'(1);
							state_q <= ST_FETCH;
						end
					end
				end
				ST_FETCH: begin
					state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					ch_q    <= '0;
					state_q <= (sel_q == SEL_ALL) ? ST_ALL : ST_WRAP;
				end
				ST_WRAP: begin
					if (mod_rsp.done) begin
						ch_q    <= mod_rsp.rem;
						state_q <= ST_ONE;
					end
				end
				ST_ONE, ST_DONE: begin
					if (emit) begin
						state_q <= ST_IDLE;
					end
				end
				ST_ALL: begin
					if (emit) begin
						ch_q <= ch_q + CH_W'(1);
						if (all_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
			endcase
		end
	end

	// selector and power of the step or direct beat being applied
	always_ff @(posedge clk) begin
		if (s_fire && (in_mode == MODE_DIRECT)) begin
			sel_q <= in_sel;
			pow_q <= in_pow;
		end else if (state_q == ST_FETCH) begin
			sel_q <= rd_data.sel;
			pow_q <= rd_data.pow;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_ch_q   <= e_ch;
			m_lvl_q  <= e_lvl;
			m_wv_q   <= e_wv;
			m_done_q <= e_done;
			m_last_q <= e_last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {5'd0, m_lvl_q, m_ch_q};
	assign m_tuser  = {m_done_q, m_wv_q};
	assign m_tlast  = m_last_q;

endmodule

[src/tops_step_mem.sv]
// step table: one write port, one read port with registered data
module tops_step_mem
	import tops_pkg::*;
(
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [STEP_AW-1:0]   wr_addr,
	input  step_entry_t          wr_data,
	input  logic                 rd_en,
	input  logic [STEP_AW-1:0]   rd_addr,
	output step_entry_t          rd_data
);

	step_entry_t step_mem [MAX_STEPS];
	step_entry_t rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			step_mem[wr_addr] <= wr_data;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= step_mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[src/tops_mod.sv]
// selector wrap unit: remainder of a 16-bit magnitude by the output count
module tops_mod
	import tops_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  mod_req_t req,
	output mod_rsp_t rsp
);

	logic            busy_q;
	logic            done_q;
	logic [2:0]      cnt_q;
	logic [15:0]     div_q;
	logic [CH_W-1:0] rem_q;
	logic [3:0]      divisor_q;
	logic [CH_W-1:0] rem_next;

	// two restoring steps per cycle
	always_comb begin
		logic [3:0] t;
		logic [CH_W-1:0] r;
		r = rem_q;
		for (int i = 0; i < 2; i++) begin
			t = {r, div_q[15 - i]};
			if (t >= divisor_q) begin
				t = t - divisor_q;
			end
			r = t[CH_W-1:0];
		end
		rem_next = r;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 3'd0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 3'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd7) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			div_q     <= req.dividend;
			rem_q     <= '0;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			div_q <= {div_q[13:0], 2'b00};
			rem_q <= rem_next;
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// self-checking testbench of the timed output pattern sequencer
module tb_top
	import tops_pkg::*;
();

	localparam int CLK_HALF    = 6;
	localparam int RST_CYCLES  = 9;
	localparam int IDLE_CYCLES = 24;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASE_ITEMS = 18;
	localparam int TICK_BUDGET = 60;
	localparam int BY_MODEL    = -1;
	localparam int WRAP_FINAL  = 40;
	localparam int WRAP_SWITCH = 20;
	localparam int WRAP_NEW_FINAL = 5;

	// one input beat, fields as the block sees them
	typedef struct packed {
		logic [1:0]  mode;
		logic [5:0]  idx;
		logic        last;
		logic [15:0] sel;
		logic [15:0] pow;
		logic [15:0] dur;
	} stim_t;

	// one output beat
	typedef struct packed {
		logic [2:0] ch;
		logic [7:0] lvl;
		logic       wv;
		logic       done;
		logic       last;
	} level_write_t;

	// directed row: n_typed of BY_MODEL means the predictor supplies the writes
	typedef struct {
		stim_t        it;
		int           n_typed;
		level_write_t want;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wen;
	logic [3:0]  cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	timed_output_pattern_sequencer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	// sequencer state as predicted
	logic [15:0] tbl_sel [MAX_STEPS];
	logic [15:0] tbl_pow [MAX_STEPS];
	logic [15:0] tbl_dur [MAX_STEPS];
	bit          tbl_written [MAX_STEPS];
	logic [5:0]  fin_step;
	logic [5:0]  cur_step;
	logic [16:0] tick_cnt;
	bit          seq_running;
	logic [3:0]  out_cnt;

	level_write_t item_writes[$];
	level_write_t pending_writes[$];
	dir_row_t     dir_rows[$];

	int cycle;
	int errors;
	int items_sent;
	int items_effective;
	int beats_seen;
	int pattern_ends;
	int settings_used;
	int stall_left;

	always #(CLK_HALF) clk = ~clk;

	// cycle count and run limit
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle >= CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d level writes still pending", $time,
				pending_writes.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// receiver stalls: mostly short, a few long, calm stretches between
	always @(posedge clk) begin
		int r;
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			m_tready <= 1'b1;
			if ((cycle % 700) >= 180 && $urandom_range(0, 99) < 22) begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					stall_left <= $urandom_range(1, 2);
				end else if (r < 95) begin
					stall_left <= $urandom_range(3, 9);
				end else begin
					stall_left <= $urandom_range(20, 50);
				end
			end
		end
	end

	task automatic check_field(input string name, input logic [7:0] want_v,
			input logic [7:0] got_v);
		if (got_v !== want_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
		end
	endtask

	// compare each output beat with the oldest pending write
	always @(posedge clk) begin
		level_write_t got;
		level_write_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[2:0], m_tdata[10:3], m_tuser[0], m_tuser[1], m_tlast};
			beats_seen++;
			if (got.done) pattern_ends++;
			if (pending_writes.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat, expected none, got ch=%0d lvl=%0d wv=%0b done=%0b last=%0b",
					$time, got.ch, got.lvl, got.wv, got.done, got.last);
			end else begin
				want = pending_writes.pop_front();
				check_field("channel", 8'(want.ch), 8'(got.ch));
				check_field("level", want.lvl, got.lvl);
				check_field("write_valid", 8'(want.wv), 8'(got.wv));
				check_field("pattern_done", 8'(want.done), 8'(got.done));
				check_field("last_of_run", 8'(want.last), 8'(got.last));
			end
		end
	end

	function automatic int used_outputs();
		int n;
		n = out_cnt;
		if (n == 0) n = 1;
		if (n > MAX_OUTPUTS) n = MAX_OUTPUTS;
		return n;
	endfunction

	// level writes of one selector and power pair
	task automatic queue_level(input logic [15:0] sel, input logic [15:0] pow);
		int s;
		int p;
		int n;
		int mag;
		level_write_t w;
		s = $signed(sel);
		p = $signed(pow);
		n = used_outputs();
		w = '0;
		w.wv = 1'b1;
		if (p < 0) begin
			w.lvl = 8'd0;
		end else if (p > 255) begin
			w.lvl = 8'd255;
		end else begin
			w.lvl = 8'(p);
		end
		if (s == -1) begin
			for (int i = 0; i < n; i++) begin
				w.ch = 3'(i);
				item_writes.push_back(w);
			end
		end else begin
			mag = (s < 0) ? -s : s;
			w.ch = 3'(mag % n);
			item_writes.push_back(w);
		end
	endtask

	// predicted writes of one accepted beat, state updated
	task automatic advance_sequencer(input stim_t it);
		level_write_t w;
		item_writes.delete();
		case (it.mode)
			MODE_LOAD: begin
				tbl_sel[it.idx] = it.sel;
				tbl_pow[it.idx] = it.pow;
				tbl_dur[it.idx] = it.dur;
				tbl_written[it.idx] = 1'b1;
				if (it.last) fin_step = it.idx;
			end
			MODE_START: begin
				cur_step = '0;
				tick_cnt = '0;
				seq_running = 1'b1;
				queue_level(tbl_sel[0], tbl_pow[0]);
			end
			MODE_TICK: if (seq_running) begin
				tick_cnt = tick_cnt + 17'd1;
				if (tick_cnt > {1'b0, tbl_dur[cur_step]}) begin
					if (cur_step == fin_step) begin
						cur_step = '0;
						seq_running = 1'b0;
						w = '0;
						w.done = 1'b1;
						item_writes.push_back(w);
					end else begin
						cur_step = cur_step + 6'd1;
						queue_level(tbl_sel[cur_step], tbl_pow[cur_step]);
					end
					tick_cnt = '0;
				end
			end
			default: begin
				queue_level(it.sel, it.pow);
			end
		endcase
		if (item_writes.size() > 0) item_writes[item_writes.size() - 1].last = 1'b1;
	endtask

	function automatic int pick_gap(input int n);
		int r;
		if ((n % 40) < 10) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// drive one beat, wait for it to be taken, then predict
	task automatic send_item(input stim_t it, input int n_typed, input level_write_t want);
		int gap;
		gap = pick_gap(items_sent);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, it.dur, it.pow, it.sel, it.idx};
		s_tuser <= it.mode;
		s_tlast <= it.last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
		if (!(it.mode == MODE_TICK && !seq_running)) items_effective++;
		advance_sequencer(it);
		if (n_typed != BY_MODEL) begin
			item_writes.delete();
			if (n_typed > 0) item_writes.push_back(want);
		end
		while (item_writes.size() > 0) pending_writes.push_back(item_writes.pop_front());
	endtask

	// let every pending write come out, then let the block settle
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_writes.size() != 0) @(posedge clk);
		repeat (IDLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_out_count(input logic [3:0] v);
		drain_results();
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen <= 1'b0;
		out_cnt = v;
		settings_used++;
	endtask

	function automatic stim_t mk_item(input logic [1:0] mode, input int idx, input bit last,
			input int sel, input int pow, input int dur);
		stim_t it;
		it.mode = mode;
		it.idx = 6'(idx);
		it.last = last;
		it.sel = 16'(sel);
		it.pow = 16'(pow);
		it.dur = 16'(dur);
		return it;
	endfunction

	function automatic dir_row_t row(input logic [1:0] mode, input int idx, input bit last,
			input int sel, input int pow, input int dur, input int n_typed, input int ch,
			input int lvl, input bit done);
		dir_row_t d;
		d.it = mk_item(mode, idx, last, sel, pow, dur);
		d.n_typed = n_typed;
		d.want = {3'(ch), 8'(lvl), !done, done, 1'b1};
		return d;
	endfunction

	function automatic int rand_sel();
		int r;
		r = $urandom_range(0, 99);
		if (r < 25) return -1;
		if (r < 50) return $urandom_range(0, 40) - 20;
		return $urandom_range(0, 65535);
	endfunction

	function automatic int rand_pow();
		int r;
		r = $urandom_range(0, 99);
		if (r < 25) return $urandom_range(0, 65535);
		if (r < 40) return $urandom_range(240, 270);
		return $urandom_range(0, 255);
	endfunction

	function automatic int short_dur();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(0, 2);
		if (r < 95) return $urandom_range(3, 8);
		return $urandom_range(9, 30);
	endfunction

	task automatic do_load(input int idx, input bit last, input int dur);
		send_item(mk_item(MODE_LOAD, idx, last, rand_sel(), rand_pow(), dur), BY_MODEL, '0);
	endtask

	// random slot; far slots may get long durations, and any slot rarely becomes the new final step
	task automatic noise_load();
		int idx;
		idx = $urandom_range(0, MAX_STEPS - 1);
		do_load(idx, $urandom_range(0, 29) == 0,
			(idx >= 8) ? $urandom_range(0, 65535) : short_dur());
	endtask

	task automatic do_direct();
		send_item(mk_item(MODE_DIRECT, $urandom_range(0, 63), $urandom_range(0, 1), rand_sel(),
			rand_pow(), $urandom_range(0, 65535)), BY_MODEL, '0);
	endtask

	// slot 0 must hold data before a start reads it
	task automatic do_start();
		if (!tbl_written[0]) do_load(0, 1'b0, short_dur());
		send_item(mk_item(MODE_START, $urandom_range(0, 63), $urandom_range(0, 1),
			$urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 65535)),
			BY_MODEL, '0);
	endtask

	// fill the next slot first when this tick would step into an empty one
	task automatic do_tick();
		logic [5:0] nxt;
		nxt = cur_step + 6'd1;
		if (seq_running && (tick_cnt + 17'd1) > {1'b0, tbl_dur[cur_step]} &&
				cur_step != fin_step && !tbl_written[nxt]) begin
			do_load(nxt, 1'b0, short_dur());
		end
		send_item(mk_item(MODE_TICK, $urandom_range(0, 63), $urandom_range(0, 1),
			$urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 65535)),
			BY_MODEL, '0);
	endtask

	// load a short pattern, start it and tick through it with some interference
	task automatic run_pattern();
		int n;
		int budget;
		int r;
		n = $urandom_range(1, 6);
		for (int s = 0; s < n; s++) begin
			if ($urandom_range(0, 9) == 0) do_direct();
			do_load(s, s == n - 1, short_dur());
		end
		do_start();
		budget = 0;
		while (seq_running && budget < TICK_BUDGET) begin
			r = $urandom_range(0, 99);
			if (r < 78) begin
				do_tick();
			end else if (r < 88) begin
				do_direct();
			end else if (r < 93) begin
				do_start();
			end else begin
				noise_load();
			end
			budget++;
		end
	endtask

	// unordered beats of any kind
	task automatic noise_burst();
		repeat (6) begin
			case ($urandom_range(0, 3))
				0: noise_load();
				1: do_start();
				2: do_tick();
				default: do_direct();
			endcase
		end
	endtask

	// full table, final step moved behind the current one so the walk wraps past slot 63
	task automatic run_wrap();
		for (int s = 0; s < MAX_STEPS; s++) do_load(s, s == WRAP_FINAL, 0);
		do_start();
		while (cur_step != 6'(WRAP_SWITCH)) do_tick();
		do_load(WRAP_NEW_FINAL, 1'b1, 0);
		while (seq_running) do_tick();
	endtask

	initial begin
		logic [3:0] settings[$];
		int start_items;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = MODE_LOAD;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		stall_left = 0;
		cycle = 0;
		errors = 0;
		items_sent = 0;
		items_effective = 0;
		beats_seen = 0;
		pattern_ends = 0;
		settings_used = 0;
		fin_step = '0;
		cur_step = '0;
		tick_cnt = '0;
		seq_running = 1'b0;
		out_cnt = OUT_COUNT_RST;
		for (int i = 0; i < MAX_STEPS; i++) begin
			tbl_written[i] = 1'b0;
			tbl_sel[i] = '0;
			tbl_pow[i] = '0;
			tbl_dur[i] = '0;
		end

		// directed rows, four outputs in use after reset
		dir_rows.push_back(row(MODE_DIRECT, 0, 0, 0, 0, 0, 1, 0, 0, 0));
		dir_rows.push_back(row(MODE_DIRECT, 0, 0, 5, 300, 0, 1, 1, 255, 0));
		dir_rows.push_back(row(MODE_DIRECT, 0, 0, -32768, -32768, 0, 1, 0, 0, 0));
		dir_rows.push_back(row(MODE_DIRECT, 0, 0, 32767, 32767, 0, 1, 3, 255, 0));
		dir_rows.push_back(row(MODE_DIRECT, 0, 0, -1, 128, 0, BY_MODEL, 0, 0, 0));
		dir_rows.push_back(row(MODE_DIRECT, 0, 0, -2, 255, 0, 1, 2, 255, 0));
		dir_rows.push_back(row(MODE_DIRECT, 0, 0, 6, 256, 0, 1, 2, 255, 0));
		dir_rows.push_back(row(MODE_DIRECT, 0, 0, 3, -1, 0, 1, 3, 0, 0));
		// tick while idle does nothing
		dir_rows.push_back(row(MODE_TICK, 63, 1, -1, 255, 65535, 0, 0, 0, 0));
		// three-step pattern plus an extreme slot that is never reached
		dir_rows.push_back(row(MODE_LOAD, 0, 0, 1, 10, 0, 0, 0, 0, 0));
		dir_rows.push_back(row(MODE_LOAD, 1, 0, -1, 20, 1, 0, 0, 0, 0));
		dir_rows.push_back(row(MODE_LOAD, 2, 1, 2, 30, 0, 0, 0, 0, 0));
		dir_rows.push_back(row(MODE_LOAD, 63, 0, -32768, 32767, 65535, 0, 0, 0, 0));
		dir_rows.push_back(row(MODE_START, 0, 0, 0, 0, 0, 1, 1, 10, 0));
		dir_rows.push_back(row(MODE_TICK, 0, 0, 0, 0, 0, BY_MODEL, 0, 0, 0));
		dir_rows.push_back(row(MODE_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(row(MODE_TICK, 0, 0, 0, 0, 0, 1, 2, 30, 0));
		// final step ends: one done beat
		dir_rows.push_back(row(MODE_TICK, 0, 0, 0, 0, 0, 1, 0, 0, 1));
		dir_rows.push_back(row(MODE_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(row(MODE_START, 0, 0, 0, 0, 0, 1, 1, 10, 0));
		dir_rows.push_back(row(MODE_TICK, 0, 0, 0, 0, 0, BY_MODEL, 0, 0, 0));
		// restart while running
		dir_rows.push_back(row(MODE_START, 0, 0, 0, 0, 0, 1, 1, 10, 0));
		// direct set leaves the sequencer alone
		dir_rows.push_back(row(MODE_DIRECT, 0, 0, -1, -5, 0, BY_MODEL, 0, 0, 0));
		dir_rows.push_back(row(MODE_TICK, 0, 0, 0, 0, 0, BY_MODEL, 0, 0, 0));

		// reset
		repeat (RST_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].n_typed, dir_rows[i].want);

		// random phases over out_count extremes and random settings
		settings = '{4'd0, 4'd15, 4'd1, 4'd8, 4'($urandom_range(2, 7)), 4'($urandom_range(1, 15))};
		foreach (settings[p]) begin
			set_out_count(settings[p]);
			start_items = items_effective;
			if (settings[p] == 4'd8) run_wrap();
			while (items_effective - start_items < PHASE_ITEMS) begin
				if ($urandom_range(0, 5) == 0) begin
					noise_burst();
				end else begin
					run_pattern();
				end
			end
		end

		drain_results();
		$display("run covered %0d input beats (%0d acted on) and %0d result beats,",
			items_sent, items_effective, beats_seen);
		$display("with %0d pattern ends over %0d out_count settings and one wrap past slot 63",
			pattern_ends, settings_used);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
